/* design/afd_pkg.sv */
// Shared types and constants for the AAF frame deframer.
package afd_pkg;

  localparam int unsigned HEADER_BYTES_DEF = 20;
  localparam int unsigned POS_W            = 18;
  localparam int unsigned SUBTYPE_RESET    = 2;
  localparam int unsigned OUT_DEPTH        = 4;
  localparam int unsigned OUT_PTR_W        = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W        = $clog2(OUT_DEPTH + 1);

  // Header byte positions
  localparam logic [POS_W-1:0] POS_SUBTYPE   = POS_W'(0);
  localparam logic [POS_W-1:0] POS_SEQ       = POS_W'(2);
  localparam logic [POS_W-1:0] POS_MAC_FIRST = POS_W'(4);
  localparam logic [POS_W-1:0] POS_MAC_LAST  = POS_W'(9);
  localparam logic [POS_W-1:0] POS_UID_FIRST = POS_W'(10);
  localparam logic [POS_W-1:0] POS_UID_LAST  = POS_W'(11);
  localparam logic [POS_W-1:0] POS_TS_FIRST  = POS_W'(12);
  localparam logic [POS_W-1:0] POS_TS_LAST   = POS_W'(15);
  localparam logic [POS_W-1:0] POS_LEN_FIRST = POS_W'(16);
  localparam logic [POS_W-1:0] POS_LEN_LAST  = POS_W'(17);
  localparam logic [POS_W-1:0] POS_MAX       = {POS_W{1'b1}};

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_REPORT  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SHORT   = 2'd1,
    ST_SUBTYPE = 2'd2,
    ST_OVERRUN = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
  } in_beat_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    status_e     status;
    logic [47:0] stream_mac;
    logic [15:0] stream_uid;
    logic [7:0]  sequence_res;
    logic [31:0] timestamp32;
    logic [15:0] payload_length;
    logic        report_last;
  } out_beat_t;

  // Result pushes from the parser into the output queue
  typedef struct packed {
    logic pay;
    logic rep;
  } afd_push_t;

endpackage

/* design/afd_parser.sv */
// Byte-position tracking, header capture and result generation.
module afd_parser #(
  parameter int unsigned HEADER_BYTES = afd_pkg::HEADER_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  afd_pkg::in_beat_t  beat_i,
  input  logic [7:0]         subtype_i,
  output afd_pkg::afd_push_t push_o,
  output afd_pkg::out_beat_t pay_o,
  output afd_pkg::out_beat_t rep_o
);
  import afd_pkg::*;

  localparam logic [POS_W-1:0] HDR_POS  = POS_W'(HEADER_BYTES);
  localparam logic [POS_W:0]   HDR_FLEN = (POS_W+1)'(HEADER_BYTES);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       sub_q, sub_d;
  logic [7:0]       seq_q, seq_d;
  logic [47:0]      mac_q, mac_d;
  logic [15:0]      uid_q, uid_d;
  logic [31:0]      ts_q, ts_d;
  logic [15:0]      len_q, len_d;

  logic [7:0]       b;
  logic [POS_W-1:0] pay_end;
  logic [POS_W:0]   flen;
  logic [POS_W:0]   need;
  logic             in_payload;
  status_e          status;

  assign b = beat_i.frame_byte;

  // Capture header fields; the report sees this byte's capture too
  always_comb begin
    sub_d = sub_q;
    seq_d = seq_q;
    mac_d = mac_q;
    uid_d = uid_q;
    ts_d  = ts_q;
    len_d = len_q;
    if (pos_q == POS_SUBTYPE) begin
      sub_d = b;
    end else if (pos_q == POS_SEQ) begin
      seq_d = b;
    end else if (pos_q >= POS_MAC_FIRST && pos_q <= POS_MAC_LAST) begin
      mac_d = {mac_q[39:0], b};
    end else if (pos_q >= POS_UID_FIRST && pos_q <= POS_UID_LAST) begin
      uid_d = {uid_q[7:0], b};
    end else if (pos_q >= POS_TS_FIRST && pos_q <= POS_TS_LAST) begin
      ts_d = {ts_q[23:0], b};
    end else if (pos_q >= POS_LEN_FIRST && pos_q <= POS_LEN_LAST) begin
      len_d = {len_q[7:0], b};
    end
  end

  assign pay_end    = HDR_POS + {{(POS_W-16){1'b0}}, len_d};
  assign in_payload = (pos_q >= HDR_POS) && (pos_q < pay_end) && (sub_d == subtype_i);

  assign flen = {1'b0, pos_q} + (POS_W+1)'(1);
  assign need = HDR_FLEN + {{(POS_W-15){1'b0}}, len_d};

  always_comb begin
    if (flen < HDR_FLEN) begin
      status = ST_SHORT;
    end else if (sub_d != subtype_i) begin
      status = ST_SUBTYPE;
    end else if (need > flen) begin
      status = ST_OVERRUN;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    pay_o              = '0;
    pay_o.kind         = KIND_PAYLOAD;
    pay_o.payload_byte = b;

    rep_o                = '0;
    rep_o.kind           = KIND_REPORT;
    rep_o.status         = status;
    rep_o.stream_mac     = mac_d;
    rep_o.stream_uid     = uid_d;
    rep_o.sequence_res   = seq_d;
    rep_o.timestamp32    = ts_d;
    rep_o.payload_length = len_d;
    rep_o.report_last    = 1'b1;

    push_o.pay = accept_i && in_payload;
    push_o.rep = accept_i && beat_i.frame_last;
  end

  // Advance the position, saturating; clear everything after the report
  always_comb begin
    if (beat_i.frame_last) begin
      pos_d = '0;
    end else if (pos_q != POS_MAX) begin
      pos_d = pos_q + POS_W'(1);
    end else begin
      pos_d = pos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      sub_q <= '0;
      seq_q <= '0;
      mac_q <= '0;
      uid_q <= '0;
      ts_q  <= '0;
      len_q <= '0;
    end else if (accept_i) begin
      pos_q <= pos_d;
      if (beat_i.frame_last) begin
        sub_q <= '0;
        seq_q <= '0;
        mac_q <= '0;
        uid_q <= '0;
        ts_q  <= '0;
        len_q <= '0;
      end else begin
        sub_q <= sub_d;
        seq_q <= seq_d;
        mac_q <= mac_d;
        uid_q <= uid_d;
        ts_q  <= ts_d;
        len_q <= len_d;
      end
    end
  end

endmodule

/* design/afd_out_fifo.sv */
// Result queue taking up to two results per cycle, draining one per beat.
module afd_out_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  afd_pkg::afd_push_t push_i,
  input  afd_pkg::out_beat_t pay_i,
  input  afd_pkg::out_beat_t rep_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output afd_pkg::out_beat_t out_beat_o
);
  import afd_pkg::*;

  out_beat_t             mem_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [OUT_PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [OUT_CNT_W-1:0]  cnt_q, cnt_d;
  logic [OUT_PTR_W-1:0]  rep_ptr;
  logic                  pop;
  logic [1:0]            n_push;

  assign pop         = (cnt_q != '0) && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_beat_o  = mem_q[rd_ptr_q];
  // Keep space for a payload byte plus a report
  assign room_o      = (cnt_q <= OUT_CNT_W'(OUT_DEPTH - 2));

  assign n_push  = {1'b0, push_i.pay} + {1'b0, push_i.rep};
  assign rep_ptr = wr_ptr_q + OUT_PTR_W'(push_i.pay);

  always_comb begin
    wr_ptr_d = wr_ptr_q + OUT_PTR_W'(n_push);
    rd_ptr_d = rd_ptr_q + OUT_PTR_W'(pop);
    cnt_d    = cnt_q + OUT_CNT_W'(n_push) - OUT_CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.pay) begin
      mem_q[wr_ptr_q] <= pay_i;
    end
    if (push_i.rep) begin
      mem_q[rep_ptr] <= rep_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

/* design/aaf_frame_deframer_core.sv */
// AAF frame deframer top level: config register, parser and result queue.
//
// Usage:
//   in channel  : one frame byte per beat (in_beat_i), frame_last on the
//                 final byte; valid/ready handshake.
//   out channel : one result per beat (out_beat_o). kind 0 carries a payload
//                 byte, kind 1 is the end-of-frame report with the captured
//                 header fields and a status; a bad status means the payload
//                 already sent for that frame must be dropped downstream.
//   cfg         : cfg_we_i writes cfg_wdata_i to the expected subtype.
// Ordering: each result enters the result queue as its byte is accepted and
//   leaves it in order. A last byte that is also a payload byte yields two
//   results, payload first, then the report.
// Throughput: one byte per cycle while in_ready_o is high; the parser is a
//   single register-to-register pass, the four-entry result queue decouples
//   the channels; a frame ending in its payload costs one extra output beat.
// Reset: position, captures and the queue clear; subtype resets to 2.
// Stall: while out_ready_i is low, results pile up in the queue; in_ready_o
//   drops once fewer than two entries are free.
module aaf_frame_deframer_core #(
  parameter int unsigned HEADER_BYTES = afd_pkg::HEADER_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  afd_pkg::in_beat_t  in_beat_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output afd_pkg::out_beat_t out_beat_o,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i
);
  import afd_pkg::*;

  logic [7:0] subtype_q;
  logic       accept;
  afd_push_t  push;
  out_beat_t  pay;
  out_beat_t  rep;

  // Hold the expected subtype
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      subtype_q <= 8'(SUBTYPE_RESET);
    end else if (cfg_we_i) begin
      subtype_q <= cfg_wdata_i;
    end
  end

  assign accept = in_valid_i && in_ready_o;

  afd_parser #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .beat_i   (in_beat_i),
    .subtype_i(subtype_q),
    .push_o   (push),
    .pay_o    (pay),
    .rep_o    (rep)
  );

  afd_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .pay_i      (pay),
    .rep_i      (rep),
    .room_o     (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_beat_o (out_beat_o)
  );

endmodule

/* tb/aaf_frame_deframer_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the AAF frame deframer: predicts result beats and compares them.
module aaf_frame_deframer_checker #(
  parameter int unsigned HEADER_BYTES = afd_pkg::HEADER_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  afd_pkg::in_beat_t  in_beat_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  afd_pkg::out_beat_t out_beat_i,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  output int                 fail_count_o,
  output int                 pending_count_o
);
  import afd_pkg::*;

  // Parser shadow state
  logic [POS_W-1:0] frame_pos;
  logic [7:0]       hdr_subtype;
  logic [7:0]       hdr_seq;
  logic [47:0]      hdr_mac;
  logic [15:0]      hdr_uid;
  logic [31:0]      hdr_ts;
  logic [15:0]      hdr_len;
  logic [7:0]       subtype_code;

  out_beat_t expected_results[$];
  out_beat_t oldest;
  int        mismatches;

  initial begin
    fail_count_o    = 0;
    pending_count_o = 0;
    mismatches      = 0;
  end

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
    end
  endtask

  task automatic clear_frame();
    frame_pos   = '0;
    hdr_subtype = '0;
    hdr_seq     = '0;
    hdr_mac     = '0;
    hdr_uid     = '0;
    hdr_ts      = '0;
    hdr_len     = '0;
  endtask

  // Capture header bytes, emit payload and the closing report.
  task automatic predict_deframe(input logic [7:0] b, input logic last);
    out_beat_t   r;
    int unsigned flen;
    if (frame_pos == POS_SUBTYPE)
      hdr_subtype = b;
    else if (frame_pos == POS_SEQ)
      hdr_seq = b;
    else if (frame_pos >= POS_MAC_FIRST && frame_pos <= POS_MAC_LAST)
      hdr_mac = {hdr_mac[39:0], b};
    else if (frame_pos >= POS_UID_FIRST && frame_pos <= POS_UID_LAST)
      hdr_uid = {hdr_uid[7:0], b};
    else if (frame_pos >= POS_TS_FIRST && frame_pos <= POS_TS_LAST)
      hdr_ts = {hdr_ts[23:0], b};
    else if (frame_pos >= POS_LEN_FIRST && frame_pos <= POS_LEN_LAST)
      hdr_len = {hdr_len[7:0], b};

    if (frame_pos >= HEADER_BYTES && frame_pos < HEADER_BYTES + hdr_len &&
        hdr_subtype == subtype_code) begin
      r              = '0;
      r.kind         = KIND_PAYLOAD;
      r.payload_byte = b;
      expected_results.push_back(r);
    end

    if (last) begin
      flen = frame_pos + 1;
      r    = '0;
      r.kind = KIND_REPORT;
      if (flen < HEADER_BYTES)
        r.status = ST_SHORT;
      else if (hdr_subtype != subtype_code)
        r.status = ST_SUBTYPE;
      else if (HEADER_BYTES + hdr_len > flen)
        r.status = ST_OVERRUN;
      else
        r.status = ST_OK;
      r.stream_mac     = hdr_mac;
      r.stream_uid     = hdr_uid;
      r.sequence_res   = hdr_seq;
      r.timestamp32    = hdr_ts;
      r.payload_length = hdr_len;
      r.report_last    = 1'b1;
      expected_results.push_back(r);
      clear_frame();
    end else if (frame_pos != POS_MAX) begin
      frame_pos = frame_pos + 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_frame();
      subtype_code = SUBTYPE_RESET[7:0];
      expected_results.delete();
      pending_count_o <= 0;
    end else begin
      // Retire the output beat first: it can never stem from this edge's input.
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $error("result beat with nothing expected: %0h", out_beat_i);
        end else begin
          oldest = expected_results.pop_front();
          check_field("kind", 64'(oldest.kind), 64'(out_beat_i.kind));
          check_field("payload_byte", 64'(oldest.payload_byte),
                      64'(out_beat_i.payload_byte));
          check_field("status", 64'(oldest.status), 64'(out_beat_i.status));
          check_field("stream_mac", 64'(oldest.stream_mac), 64'(out_beat_i.stream_mac));
          check_field("stream_uid", 64'(oldest.stream_uid), 64'(out_beat_i.stream_uid));
          check_field("sequence_res", 64'(oldest.sequence_res),
                      64'(out_beat_i.sequence_res));
          check_field("timestamp32", 64'(oldest.timestamp32),
                      64'(out_beat_i.timestamp32));
          check_field("payload_length", 64'(oldest.payload_length),
                      64'(out_beat_i.payload_length));
          check_field("report_last", 64'(oldest.report_last),
                      64'(out_beat_i.report_last));
        end
      end
      if (in_valid_i && in_ready_i)
        predict_deframe(in_beat_i.frame_byte, in_beat_i.frame_last);
      if (cfg_we_i)
        subtype_code = cfg_wdata_i;
      pending_count_o <= expected_results.size();
    end
    fail_count_o <= mismatches;
  end

endmodule

/* tb/tb_aaf_frame_deframer_core.sv */
`timescale 1ns / 1ps
// Testbench top for the AAF frame deframer: clock, reset, frame stimulus and verdict.
module tb_aaf_frame_deframer_core;
  import afd_pkg::*;

  localparam int unsigned HDR          = HEADER_BYTES_DEF;
  localparam int unsigned RANDOM_ITEMS = 650;
  localparam int unsigned LONG_HOLD    = 150;     // receiver hold-off in cycles
  localparam int unsigned SETTLE       = 4;       // cycles after the last result
  localparam int unsigned DRAIN        = 8;       // cycles after the run drains
  localparam int unsigned CYCLE_LIMIT  = 200000;  // far above a fully stalled run

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid;
  logic       in_ready;
  in_beat_t   in_beat;
  logic       out_valid;
  logic       out_ready;
  out_beat_t  out_beat;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  int         fail_count;
  int         pending;

  // Stimulus-side knobs; stall_reqs is shared with the receiver process
  bit         sender_gaps;
  int         stall_reqs;
  int         items_sent;
  logic [7:0] cur_code;

  aaf_frame_deframer_core #(
    .HEADER_BYTES(HDR)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_beat_i  (in_beat),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_beat_o (out_beat),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  aaf_frame_deframer_checker #(
    .HEADER_BYTES(HDR)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .in_beat_i      (in_beat),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_beat_i     (out_beat),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .fail_count_o   (fail_count),
    .pending_count_o(pending)
  );

  // 12 ns clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Assert reset at the start, then release it for good.
  initial begin
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Offer one input beat: with sender_gaps set, idle for a random gap; then
  // hold valid and the payload until the block takes the beat.
  task automatic send_beat(input logic [7:0] b, input logic last);
    int gap;
    gap = sender_gaps ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_beat  <= '{frame_byte: b, frame_last: last};
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    items_sent++;
  endtask

  // Write the expected subtype once the block has drained. A byte that
  // causes no result may still be in flight, so let the block settle first.
  task automatic program_subtype(input logic [7:0] code);
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_wdata <= code;
    cfg_we    <= 1'b1;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    cur_code  = code;
  endtask

  // Send a whole frame. Byte 0 carries the subtype, bytes 16-17 the
  // declared length; other header bytes take the fill value (random when
  // fill is negative), and everything past the header is random. When
  // cfg_at is not negative, rewrite the subtype just before that byte.
  task automatic send_frame(input logic [7:0] subtype, input logic [15:0] len_field,
                            input int unsigned total, input int fill,
                            input int cfg_at, input logic [7:0] cfg_val);
    logic [7:0] b;
    for (int unsigned i = 0; i < total; i++) begin
      if (i == cfg_at)
        program_subtype(cfg_val);
      if (i == 0)
        b = subtype;
      else if (i == 16)
        b = len_field[15:8];
      else if (i == 17)
        b = len_field[7:0];
      else if (i < HDR && fill >= 0)
        b = fill[7:0];
      else
        b = 8'($urandom_range(0, 255));
      send_beat(b, i == total - 1);
    end
  endtask

  // Receiver: wait a random number of cycles per beat, with eager stretches,
  // and hold off for a long stretch whenever the stimulus asks for it.
  initial begin : result_sink
    int wait_cycles;
    int seen_stalls;
    int beats;
    bit eager;
    seen_stalls = 0;
    beats       = 0;
    eager       = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (stall_reqs != seen_stalls) begin
        // Hold ready low so the queue fills and the input stalls.
        seen_stalls = stall_reqs;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      if (beats % 24 == 0)
        eager = ($urandom_range(0, 3) == 0);
      wait_cycles = eager ? 0 : $urandom_range(0, 9);
      if (wait_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
      beats++;
    end
  end

  // Cycle budget: end the run as failed if it never drains.
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int          frames;
    int          pick;
    int unsigned len;
    int unsigned total;
    int unsigned random_start;
    logic [7:0]  code;

    in_valid    <= 1'b0;
    in_beat     <= '0;
    cfg_we      <= 1'b0;
    cfg_wdata   <= '0;
    sender_gaps = 1'b1;
    stall_reqs  = 0;
    items_sent  = 0;
    cur_code    = SUBTYPE_RESET[7:0];

    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);

    // Directed: one-byte frame, too short, nothing captured beyond byte 0.
    send_frame(8'hFF, 16'h0000, 1, 255, -1, 8'h00);
    // Directed: reset subtype, all other header fields at their maximum and the
    // largest declared length; the frame ends on its first payload byte,
    // so a payload beat precedes an overrun report.
    send_frame(cur_code, 16'hFFFF, HDR + 1, 255, -1, 8'h00);
    // Directed: zero header with subtype 0 written in the middle of the
    // header, then a full payload and two trailing bytes to drop.
    send_frame(8'h00, 16'h0005, HDR + 7, 0, 8, 8'h00);

    // Random frames: mostly well formed, the rest short, mismatched,
    // overrunning or carrying huge declared lengths.
    random_start = items_sent;
    frames       = 0;
    while (items_sent < random_start + RANDOM_ITEMS) begin
      if (frames % 6 == 5) begin
        case ($urandom_range(0, 3))
          0:       code = 8'h00;
          1:       code = 8'hFF;
          2:       code = SUBTYPE_RESET[7:0];
          default: code = 8'($urandom_range(0, 255));
        endcase
        program_subtype(code);
      end
      if (frames % 4 == 0)
        sender_gaps = ($urandom_range(0, 3) != 0);
      if (frames == 3 || frames == 14)
        stall_reqs++;
      if (frames == 9) begin
        // Pause the sender until every result has come back.
        in_valid <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end

      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        len   = $urandom_range(0, 24);
        total = HDR + len + $urandom_range(0, 4);
        send_frame(cur_code, 16'(len), total, -1, -1, 8'h00);
      end else if (pick < 70) begin
        total = $urandom_range(1, HDR - 1);
        code  = $urandom_range(0, 1) ? cur_code : 8'($urandom_range(0, 255));
        send_frame(code, 16'($urandom_range(0, 65535)), total, -1, -1, 8'h00);
      end else if (pick < 80) begin
        len   = $urandom_range(0, 16);
        total = HDR + len + $urandom_range(0, 3);
        code  = cur_code ^ 8'($urandom_range(1, 255));
        send_frame(code, 16'(len), total, -1, -1, 8'h00);
      end else if (pick < 92) begin
        len   = $urandom_range(1, 24);
        total = HDR + $urandom_range(0, len - 1);
        send_frame(cur_code, 16'(len), total, -1, -1, 8'h00);
      end else begin
        len   = $urandom_range(0, 65535);
        total = HDR + $urandom_range(0, 30);
        send_frame(cur_code, 16'(len), total, -1, -1, 8'h00);
      end
      frames++;
    end

    // Drain: drop valid, wait for every expected beat, then settle.
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    if (fail_count == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
